// ===== rtl/running_median_tracker_macros.svh =====
// assertion macros used by the checker file
`ifndef RUNNING_MEDIAN_TRACKER_MACROS_SVH
`define RUNNING_MEDIAN_TRACKER_MACROS_SVH

// implication checked in the same cycle
`define RMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("running median tracker check failed");

// implication checked in the next cycle
`define RMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("running median tracker check failed");

`endif

// ===== rtl/rmt_pkg.sv =====
// shared types and constants of the running median tracker
`timescale 1ns / 1ps
`default_nettype none
package rmt_pkg;

  localparam int CAPACITY  = 256;
  localparam int SAMPLE_W  = 24;
  localparam int MEDIAN_W  = SAMPLE_W + 1;
  localparam int ENTRY_W   = 9;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((MEDIAN_W + ENTRY_W + 7) / 8) * 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [IDX_W-1:0]           idx_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic    load;
    sample_t sample;
    count_t  count;
    idx_t    lo;
    idx_t    hi;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/rmt_cell.sv =====
// one insertion cell of the sorted chain
`timescale 1ns / 1ps
`default_nettype none
module rmt_cell import rmt_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  idx_t       idx_i,
  input  sample_t    prev_val_i,
  input  logic       prev_gt_i,
  output sample_t    val_o,
  output logic       gt_o,
  output sample_t    lo_o,
  output sample_t    hi_o
);

  sample_t val_q, val_d;
  logic    occupied, at_end;

  always_comb begin
    occupied = CNT_W'(idx_i) < ctrl_i.count;
    at_end   = CNT_W'(idx_i) == ctrl_i.count;
    gt_o     = occupied && (val_q > ctrl_i.sample);
    val_d    = val_q;
    // shift up from the neighbour or take the new item
    if (gt_o || at_end) begin
      val_d = prev_gt_i ? prev_val_i : ctrl_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
  assign lo_o  = (idx_i == ctrl_i.lo) ? val_q : '0;
  assign hi_o  = (idx_i == ctrl_i.hi) ? val_q : '0;

endmodule
`default_nettype wire

// ===== rtl/running_median_tracker.sv =====
// Running median tracker: each item carries a signed Q15.8 sample and a restart
// flag; the sample is inserted into a sorted chain of 256 cells and one result
// gives twice the median of all samples held since the last restart, the entry
// count and a flag set when the store was already full and the sample dropped.
// The chain inserts an item in its accept cycle, state SEL then registers the two
// middle cells, and state ADD adds them into the output register once that is free.
// A new item is taken while the previous result still waits there.
`timescale 1ns / 1ps
`default_nettype none
module running_median_tracker import rmt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // sample
  input  logic                  s_axis_tuser,  // restart
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // median_doubled, entry_count, zero pad
  output logic                  m_axis_tuser   // store_full
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  logic [1:0] state_q, state_d;
  count_t     count_q, count_d, eff_count;
  logic       accept, full, out_valid_q, out_load, dropped_q;
  sample_t    lo_sel, hi_sel, lo_q, hi_q;
  median_t    out_median_q, sum;
  logic [ENTRY_W-1:0] out_count_q;
  logic       out_full_q;
  cell_ctrl_t ctrl;

  sample_t vals [CAPACITY];
  logic    gts  [CAPACITY];
  sample_t los  [CAPACITY];
  sample_t his  [CAPACITY];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign eff_count     = s_axis_tuser ? '0 : count_q;
  assign full          = (eff_count == CNT_W'(CAPACITY));

  always_comb begin
    ctrl.load   = accept && !full;
    ctrl.sample = s_axis_tdata[SAMPLE_W-1:0];
    ctrl.count  = eff_count;
    ctrl.lo     = IDX_W'((count_q - CNT_W'(1)) >> 1);
    ctrl.hi     = IDX_W'(count_q >> 1);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      rmt_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .idx_i      (IDX_W'(i)),
        .prev_val_i ('0),
        .prev_gt_i  (1'b0),
        .val_o      (vals[i]),
        .gt_o       (gts[i]),
        .lo_o       (los[i]),
        .hi_o       (his[i])
      );
    end else begin : g_rest
      rmt_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .idx_i      (IDX_W'(i)),
        .prev_val_i (vals[i-1]),
        .prev_gt_i  (gts[i-1]),
        .val_o      (vals[i]),
        .gt_o       (gts[i]),
        .lo_o       (los[i]),
        .hi_o       (his[i])
      );
    end
  end

  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      lo_sel = lo_sel | los[i];
      hi_sel = hi_sel | his[i];
    end
  end

  assign sum      = MEDIAN_W'(lo_q) + MEDIAN_W'(hi_q);
  assign out_load = (state_q == ST_ADD) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SEL;
          count_d = full ? eff_count : eff_count + CNT_W'(1);
        end
      end
      ST_SEL: state_d = ST_ADD;
      ST_ADD: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dropped_q <= full;
    end
    if (state_q == ST_SEL) begin
      lo_q <= lo_sel;
      hi_q <= hi_sel;
    end
    if (out_load) begin
      out_median_q <= sum;
      out_count_q  <= ENTRY_W'(count_q);
      out_full_q   <= dropped_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_count_q, out_median_q});
  assign m_axis_tuser  = out_full_q;

endmodule
`default_nettype wire

// ===== rtl/rmt_checker.sv =====
// port checks of the running median tracker and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "running_median_tracker_macros.svh"
module rmt_checker import rmt_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic                  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser
);

  logic [ENTRY_W-1:0] entry_count;
  logic               in_wait;
  logic               out_wait;

  assign entry_count = m_axis_tdata[MEDIAN_W+ENTRY_W-1:MEDIAN_W];
  assign in_wait     = s_axis_tvalid && !s_axis_tready;
  assign out_wait    = m_axis_tvalid && !m_axis_tready;

  // stalled result holds
  `RMT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // offered item holds while it waits
  `RMT_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_wait, s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
  // a held store is never empty
  `RMT_ASSERT_SAME(a_count_nonzero, clk_i, rst_ni, m_axis_tvalid, entry_count != '0)
  // a dropped item only with a full store
  `RMT_ASSERT_SAME(a_full_count, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, entry_count == ENTRY_W'(CAPACITY))
  // one item at a time in the chain
  `RMT_ASSERT_NEXT(a_busy_after_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind running_median_tracker rmt_checker u_rmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== verif/running_median_tracker_test.sv =====
// self-checking testbench for the running median tracker
`timescale 1ns / 1ps
module running_median_tracker_test;
  import rmt_pkg::*;

  localparam int N_ITEMS    = 1900;
  localparam int DRAIN_AT   = 700;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 120;
  localparam int TAIL_WAIT  = 12;
  localparam int SPARE_BITS = OUT_DATA_W - MEDIAN_W - ENTRY_W;

  typedef struct {
    sample_t sample;
    logic    restart;
  } sample_item_t;

  typedef struct {
    median_t            median;
    logic [ENTRY_W-1:0] count;
    logic               full;
  } median_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // sample
  logic                  s_axis_tuser = 1'b0; // restart
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // median_doubled, entry_count, zero pad
  logic                  m_axis_tuser;        // store_full

  sample_item_t   pending_samples[$];
  median_result_t median_expect[$];
  sample_t        sorted_held[$];
  int             queued_total = 0;
  int             taken_cnt = 0;
  int             error_cnt = 0;
  logic           in_fire = 1'b0;
  logic           rx_hold = 1'b0;
  logic           drain_done = 1'b0;

  running_median_tracker uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d (item result %0d)", what, got, want,
             taken_cnt);
    error_cnt++;
  endtask

  // insert into the sorted copy and work out the result this item gives
  function automatic median_result_t track_median(input sample_t x, input logic restart);
    median_result_t r;
    int             pos;
    int             n;
    longint         a;
    longint         b;
    r.full = 1'b0;
    if (restart) begin
      sorted_held.delete();
    end
    if (sorted_held.size() < CAPACITY) begin
      pos = 0;
      while (pos < sorted_held.size() && sorted_held[pos] <= x) pos++;
      sorted_held.insert(pos, x);
    end else begin
      r.full = 1'b1;
    end
    n = sorted_held.size();
    if (n % 2 == 1) begin
      a = sorted_held[(n - 1) / 2];
      b = a;
    end else begin
      a = sorted_held[n / 2];
      b = sorted_held[n / 2 - 1];
    end
    r.median = median_t'(a + b);
    r.count  = ENTRY_W'(n);
    return r;
  endfunction

  function automatic sample_t pick_sample(input int mode);
    sample_t s;
    case (mode)
      0: s = sample_t'($urandom);
      1: s = sample_t'($urandom_range(16)) - sample_t'(8);
      2: s = ($urandom_range(1) == 1) ? sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}})
                                       : sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}});
      default: s = sample_t'($urandom_range(4095)) - sample_t'(2048);
    endcase
    return s;
  endfunction

  task automatic queue_sample(input sample_t s, input logic restart);
    sample_item_t it;
    it.sample  = s;
    it.restart = restart;
    pending_samples.insert(pending_samples.size(), it);
    queued_total++;
  endtask

  // sender: next item offered at the falling edge
  always @(negedge clk_i) begin
    sample_item_t cur;
    int           idle_pct;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      idle_pct = (taken_cnt < N_ITEMS / 3) ? 29 : (taken_cnt < 2 * N_ITEMS / 3) ? 55 : 0;
      if (taken_cnt == DRAIN_AT && !drain_done && median_expect.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
        if (taken_cnt == DRAIN_AT) drain_done <= 1'b1;
        cur = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'($unsigned(cur.sample));
        s_axis_tuser  <= cur.restart;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    int idle_pct;
    idle_pct = (taken_cnt < N_ITEMS / 3) ? 55 : (taken_cnt < 2 * N_ITEMS / 3) ? 29 : 0;
    m_axis_tready <= rst_ni && !rx_hold && ($urandom_range(99) >= idle_pct);
  end

  // long receiver hold-off so the block backs up
  initial begin
    wait (taken_cnt >= HOLD_AT);
    @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    @(negedge clk_i);
    rx_hold = 1'b0;
  end

  // monitor: check results, then predict for accepted items
  always @(posedge clk_i) begin
    median_result_t want;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (median_expect.size() == 0) begin
          report_mismatch("unexpected result, median", longint'($signed(
                          m_axis_tdata[MEDIAN_W-1:0])), 0);
        end else begin
          want = median_expect.pop_front();
          if (median_t'(m_axis_tdata[MEDIAN_W-1:0]) !== want.median)
            report_mismatch("median_doubled",
                            longint'($signed(m_axis_tdata[MEDIAN_W-1:0])),
                            longint'(want.median));
          if (m_axis_tdata[MEDIAN_W +: ENTRY_W] !== want.count)
            report_mismatch("entry_count", longint'(m_axis_tdata[MEDIAN_W +: ENTRY_W]),
                            longint'(want.count));
          if (m_axis_tuser !== want.full)
            report_mismatch("store_full", longint'(m_axis_tuser), longint'(want.full));
          if (m_axis_tdata[OUT_DATA_W-1 -: SPARE_BITS] !== '0)
            report_mismatch("pad bits", longint'(m_axis_tdata[OUT_DATA_W-1 -: SPARE_BITS]),
                            0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        median_expect.insert(median_expect.size(),
                             track_median(sample_t'(s_axis_tdata[SAMPLE_W-1:0]),
                                          s_axis_tuser));
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  initial begin
    int run_len;
    int mode;
    int r;
    // extremes, restart and equal values
    queue_sample(sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}}), 1'b1);
    queue_sample(sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}}), 1'b0);
    queue_sample(sample_t'(0), 1'b0);
    queue_sample(sample_t'(-1), 1'b0);
    queue_sample(sample_t'(1), 1'b0);
    queue_sample(sample_t'(1), 1'b0);
    queue_sample(sample_t'(1), 1'b0);
    queue_sample(sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}}), 1'b1);
    queue_sample(sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}}), 1'b0);
    queue_sample(sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}}), 1'b1);
    queue_sample(sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}}), 1'b0);
    queue_sample(sample_t'(24'h555555), 1'b1);
    queue_sample(sample_t'(24'haaaaaa), 1'b0);
    queue_sample(sample_t'(-256), 1'b0);
    queue_sample(sample_t'(256), 1'b0);
    queue_sample(sample_t'(-3), 1'b1);
    queue_sample(sample_t'(3), 1'b1);
    queue_sample(sample_t'(-2), 1'b0);
    // first random run always goes past full
    run_len = 270;
    mode = 0;
    while (queued_total < N_ITEMS) begin
      for (int i = 0; i < run_len && queued_total < N_ITEMS; i++) begin
        queue_sample(pick_sample(($urandom_range(9) == 0) ? $urandom_range(3) : mode),
                     (i == 0) ? 1'b1 : 1'b0);
      end
      r = $urandom_range(99);
      if (r < 8) run_len = $urandom_range(300, 256);
      else if (r < 50) run_len = $urandom_range(8, 1);
      else run_len = $urandom_range(60, 9);
      mode = $urandom_range(3);
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_samples.size() == 0 && taken_cnt == queued_total);
    wait (median_expect.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (error_cnt == 0 && median_expect.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
